/* hdl/akf_pkg.sv */
// Shared constants, command codes and control structs for the angle Kalman filter core.
`timescale 1ns / 1ps
`default_nettype none

package akf_pkg;

  // Fixed field widths of the ports.
  localparam int IO_W      = 32;
  localparam int CFG_W     = 31;
  localparam int CFG_IDX_W = 2;

  // Internal wide arithmetic: sums of clamped products stay well inside 64 bits.
  localparam int ACC_W  = 64;
  localparam int FRAC_C = 28;

  localparam int WORD_WIDTH_DEF = 32;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_NOISE_ANGLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NOISE_BIAS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NOISE_MEAS  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_TIME   = 2'd3;

  // Register reset values, unsigned Q3.28.
  localparam logic [CFG_W-1:0] RST_NOISE_ANGLE = 31'd268435;
  localparam logic [CFG_W-1:0] RST_NOISE_BIAS  = 31'd805306;
  localparam logic [CFG_W-1:0] RST_NOISE_MEAS  = 31'd8053064;
  localparam logic [CFG_W-1:0] RST_STEP_TIME   = 31'd2684355;

  // Product magnitude clamp and quotient magnitude clamp.
  localparam logic [ACC_W-1:0] PRODCLAMP = 64'h1000_0000_0000_0000;
  localparam logic [ACC_W-1:0] BIGMAG    = 64'h0010_0000_0000_0000;

  // Datapath update operations, applied once an operand or unit result is ready.
  typedef enum logic [4:0] {
    OP_NONE,
    OP_RATE,
    OP_ANG_PRED,
    OP_SAVE_DP,
    OP_T,
    OP_P00_PRED,
    OP_P01_PRED,
    OP_P11_PRED,
    OP_S,
    OP_K0,
    OP_K1,
    OP_Y,
    OP_ANG_UPD,
    OP_BIAS_UPD,
    OP_P11_UPD,
    OP_P10_UPD,
    OP_P00_UPD
  } op_t;

  // Multiplier operand pairs (first operand is the narrow one).
  typedef enum logic [3:0] {
    M_DT_RATE,
    M_DT_P11,
    M_DT_T,
    M_QB_DT,
    M_K0_Y,
    M_K1_Y,
    M_K0_P01,
    M_K1_P01,
    M_K1_P00,
    M_K0_P00
  } msel_t;

  // Divider numerators.
  typedef enum logic {
    D_P00,
    D_P10
  } dsel_t;

  typedef struct packed {
    logic  load;
    logic  mul_start;
    msel_t msel;
    logic  div_start;
    dsel_t dsel;
    op_t   op;
    logic  out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic s_pos;
    logic out_full;
  } dp_status_t;

endpackage

`default_nettype wire

/* hdl/akf_if.sv */
// Request channel interfaces for measurement input and filtered result output.
`timescale 1ns / 1ps
`default_nettype none

interface akf_in_if import akf_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [IO_W-1:0] measured_angle;
  logic signed [IO_W-1:0] measured_rate;

  modport source (output valid, output measured_angle, output measured_rate, input ready);
  modport sink   (input valid, input measured_angle, input measured_rate, output ready);
endinterface

interface akf_out_if import akf_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [IO_W-1:0] filtered_angle;
  logic signed [IO_W-1:0] bias_estimate;
  logic                   saturated;

  modport source (output valid, output filtered_angle, output bias_estimate,
                  output saturated, input ready);
  modport sink   (input valid, input filtered_angle, input bias_estimate,
                  input saturated, output ready);
endinterface

`default_nettype wire

/* hdl/akf_mul.sv */
// Bit-serial fixed-point multiplier: round(a*b / 2^28), magnitude clamped.
`timescale 1ns / 1ps
`default_nettype none

module akf_mul import akf_pkg::*; #(
  parameter int AW = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [AW-1:0]    a,
  input  logic signed [ACC_W-1:0] b,
  output logic                    done,
  output logic signed [ACC_W-1:0] res
);

  localparam int PW = AW + ACC_W;
  localparam int CW = $clog2(AW + 1);
  localparam int MW = PW - FRAC_C;

  logic             busy;
  logic [CW-1:0]    cnt;
  logic [AW-1:0]    am;
  logic [ACC_W-1:0] bm;
  logic [PW-1:0]    acc;
  logic             neg;

  logic [PW-1:0]    rnd;
  logic [MW-1:0]    mag_w;
  logic [ACC_W-1:0] mag_c;

  always_comb begin
    rnd   = acc + (PW'(1) << (FRAC_C - 1));
    mag_w = rnd[PW-1:FRAC_C];
    mag_c = (mag_w > MW'(PRODCLAMP)) ? PRODCLAMP : mag_w[ACC_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        am   <= a[AW-1] ? (~a + 1'b1) : a;
        bm   <= b[ACC_W-1] ? (~b + 1'b1) : b;
        acc  <= '0;
        neg  <= a[AW-1] ^ b[ACC_W-1];
      end else if (busy) begin
        if (cnt == CW'(AW)) begin
          res  <= neg ? -$signed(mag_c) : $signed(mag_c);
          done <= 1'b1;
          busy <= 1'b0;
        end else begin
          acc <= (acc << 1) + (am[AW-1] ? PW'(bm) : '0);
          am  <= am << 1;
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

/* hdl/akf_div.sv */
// Restoring divider: round((n << 28) / d) for d > 0, magnitude clamped.
`timescale 1ns / 1ps
`default_nettype none

module akf_div import akf_pkg::*; #(
  parameter int W = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [W-1:0]     n,
  input  logic [ACC_W-1:0]        d,
  output logic                    done,
  output logic signed [ACC_W-1:0] res
);

  localparam int NW = W + FRAC_C;
  localparam int CW = $clog2(NW + 1);
  localparam int QW = (NW > 53) ? NW : 53;

  logic             busy;
  logic [CW-1:0]    cnt;
  logic [NW-1:0]    num;
  logic [NW-1:0]    quo;
  logic [ACC_W:0]   rem;
  logic [ACC_W-1:0] dd;
  logic             neg;

  logic [ACC_W:0]   rsh;
  logic             ge;
  logic [QW-1:0]    qx;
  logic [QW-1:0]    qfin;
  logic             up;
  logic [W-1:0]     un;

  always_comb begin
    un   = n[W-1] ? (~n + 1'b1) : n;
    rsh  = {rem[ACC_W-1:0], num[NW-1]};
    ge   = rsh >= {1'b0, dd};
    qx   = QW'(quo);
    up   = {rem, 1'b0} >= {2'b00, dd};
    if (qx > QW'(BIGMAG)) begin
      qfin = QW'(BIGMAG);
    end else begin
      qfin = qx + QW'(up);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        num  <= {un, {FRAC_C{1'b0}}};
        quo  <= '0;
        rem  <= '0;
        dd   <= d;
        neg  <= n[W-1];
      end else if (busy) begin
        if (cnt == CW'(NW)) begin
          res  <= neg ? -$signed(ACC_W'(qfin)) : $signed(ACC_W'(qfin));
          done <= 1'b1;
          busy <= 1'b0;
        end else begin
          rem <= ge ? (rsh - {1'b0, dd}) : rsh;
          quo <= {quo[NW-2:0], ge};
          num <= num << 1;
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

/* hdl/akf_datapath.sv */
// Filter state, configuration registers, shared multiplier and divider, result register.
`timescale 1ns / 1ps
`default_nettype none

module akf_datapath import akf_pkg::*; #(
  parameter int W = WORD_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  ctrl_cmd_t              cmd,
  output dp_status_t             status,
  input  logic signed [IO_W-1:0] in_angle,
  input  logic signed [IO_W-1:0] in_rate,
  input  logic                   write_enable,
  input  logic [CFG_IDX_W-1:0]   reg_index,
  input  logic [CFG_W-1:0]       write_data,
  input  logic                   out_ready,
  output logic                   out_valid,
  output logic signed [IO_W-1:0] out_angle,
  output logic signed [IO_W-1:0] out_bias,
  output logic                   out_sat
);

  localparam int AW = (W > 32) ? W : 32;

  function automatic logic ovf_w(input logic signed [ACC_W-1:0] x);
    logic [ACC_W-W:0] top;
    top = x[ACC_W-1:W-1];
    return !((&top) || (~|top));
  endfunction

  function automatic logic signed [W-1:0] sat_w(input logic signed [ACC_W-1:0] x);
    logic signed [W-1:0] r;
    if (!ovf_w(x)) begin
      r = x[W-1:0];
    end else if (x[ACC_W-1]) begin
      r = {1'b1, {(W-1){1'b0}}};
    end else begin
      r = {1'b0, {(W-1){1'b1}}};
    end
    return r;
  endfunction

  function automatic logic ovf_io(input logic signed [ACC_W-1:0] x);
    logic [ACC_W-IO_W:0] top;
    top = x[ACC_W-1:IO_W-1];
    return !((&top) || (~|top));
  endfunction

  function automatic logic signed [IO_W-1:0] sat_io(input logic signed [ACC_W-1:0] x);
    logic signed [IO_W-1:0] r;
    if (!ovf_io(x)) begin
      r = x[IO_W-1:0];
    end else if (x[ACC_W-1]) begin
      r = {1'b1, {(IO_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(IO_W-1){1'b1}}};
    end
    return r;
  endfunction

  // configuration
  logic [CFG_W-1:0] noise_angle, noise_bias, noise_meas, step_time;

  // filter state and scratch
  logic signed [W-1:0]     ang, bias, p00, p01, p10, p11;
  logic signed [W-1:0]     rt, k0, k1;
  logic signed [ACC_W-1:0] dp, tt, s, y;
  logic signed [IO_W-1:0]  ma, mr;
  logic                    clip;

  // shared units
  logic signed [AW-1:0]    mul_a;
  logic signed [ACC_W-1:0] mul_b, mres, dres;
  logic                    mul_done, div_done;
  logic signed [W-1:0]     div_n;

  logic signed [ACC_W-1:0] x1, x2;
  logic                    two;

  always_comb begin
    mul_a = AW'(step_time);
    mul_b = ACC_W'(rt);
    case (cmd.msel)
      M_DT_RATE: begin mul_a = AW'(step_time);  mul_b = ACC_W'(rt);        end
      M_DT_P11:  begin mul_a = AW'(step_time);  mul_b = ACC_W'(p11);       end
      M_DT_T:    begin mul_a = AW'(step_time);  mul_b = tt;                end
      M_QB_DT:   begin mul_a = AW'(noise_bias); mul_b = ACC_W'(step_time); end
      M_K0_Y:    begin mul_a = AW'(k0);         mul_b = y;                 end
      M_K1_Y:    begin mul_a = AW'(k1);         mul_b = y;                 end
      M_K0_P01:  begin mul_a = AW'(k0);         mul_b = ACC_W'(p01);       end
      M_K1_P01:  begin mul_a = AW'(k1);         mul_b = ACC_W'(p01);       end
      M_K1_P00:  begin mul_a = AW'(k1);         mul_b = ACC_W'(p00);       end
      M_K0_P00:  begin mul_a = AW'(k0);         mul_b = ACC_W'(p00);       end
      default:   begin mul_a = AW'(step_time);  mul_b = ACC_W'(rt);        end
    endcase
    div_n = (cmd.dsel == D_P10) ? p10 : p00;
  end

  akf_mul #(.AW(AW)) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .res   (mres)
  );

  akf_div #(.W(W)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .n     (div_n),
    .d     (s),
    .done  (div_done),
    .res   (dres)
  );

  // Wide sum for the current update; the second applies to paired covariance updates.
  always_comb begin
    x1  = '0;
    x2  = '0;
    two = 1'b0;
    case (cmd.op)
      OP_RATE:     x1 = ACC_W'(mr) - ACC_W'(bias);
      OP_ANG_PRED: x1 = ACC_W'(ang) + mres;
      OP_P00_PRED: x1 = ACC_W'(p00) + mres;
      OP_P01_PRED: begin
        x1  = ACC_W'(p01) - dp;
        x2  = ACC_W'(p10) - dp;
        two = 1'b1;
      end
      OP_P11_PRED: x1 = ACC_W'(p11) + mres;
      OP_K0:       x1 = dres;
      OP_K1:       x1 = dres;
      OP_ANG_UPD:  x1 = ACC_W'(ang) + mres;
      OP_BIAS_UPD: x1 = ACC_W'(bias) + mres;
      OP_P11_UPD: begin
        x1  = ACC_W'(p11) - mres;
        x2  = ACC_W'(p01) - dp;
        two = 1'b1;
      end
      OP_P10_UPD:  x1 = ACC_W'(p10) - mres;
      OP_P00_UPD:  x1 = ACC_W'(p00) - mres;
      default: begin
        x1 = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      noise_angle <= RST_NOISE_ANGLE;
      noise_bias  <= RST_NOISE_BIAS;
      noise_meas  <= RST_NOISE_MEAS;
      step_time   <= RST_STEP_TIME;
      ang         <= '0;
      bias        <= '0;
      p00         <= '0;
      p01         <= '0;
      p10         <= '0;
      p11         <= '0;
      clip        <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (write_enable) begin
        case (reg_index)
          CFG_NOISE_ANGLE: noise_angle <= write_data;
          CFG_NOISE_BIAS:  noise_bias  <= write_data;
          CFG_NOISE_MEAS:  noise_meas  <= write_data;
          CFG_STEP_TIME:   step_time   <= write_data;
          default:         noise_angle <= noise_angle;
        endcase
      end

      if (cmd.load) begin
        ma   <= in_angle;
        mr   <= in_rate;
        clip <= 1'b0;
        k0   <= '0;
        k1   <= '0;
      end else if (cmd.op != OP_NONE) begin
        clip <= clip | (ovf_w(x1) & (cmd.op != OP_SAVE_DP) & (cmd.op != OP_T)
                        & (cmd.op != OP_S) & (cmd.op != OP_Y))
                     | (two & ovf_w(x2));
      end

      case (cmd.op)
        OP_RATE:     rt   <= sat_w(x1);
        OP_ANG_PRED: ang  <= sat_w(x1);
        OP_SAVE_DP:  dp   <= mres;
        OP_T:        tt   <= dp - ACC_W'(p01) - ACC_W'(p10) + ACC_W'(noise_angle);
        OP_P00_PRED: p00  <= sat_w(x1);
        OP_P01_PRED: begin
          p01 <= sat_w(x1);
          p10 <= sat_w(x2);
        end
        OP_P11_PRED: p11  <= sat_w(x1);
        OP_S:        s    <= ACC_W'(p00) + ACC_W'(noise_meas);
        OP_K0:       k0   <= sat_w(x1);
        OP_K1:       k1   <= sat_w(x1);
        OP_Y:        y    <= ACC_W'(ma) - ACC_W'(ang);
        OP_ANG_UPD:  ang  <= sat_w(x1);
        OP_BIAS_UPD: bias <= sat_w(x1);
        OP_P11_UPD: begin
          p11 <= sat_w(x1);
          p01 <= sat_w(x2);
        end
        OP_P10_UPD:  p10  <= sat_w(x1);
        OP_P00_UPD:  p00  <= sat_w(x1);
        default: begin
          dp <= dp;
        end
      endcase

      if (cmd.out_load) begin
        out_valid <= 1'b1;
        out_angle <= sat_io(ACC_W'(ang));
        out_bias  <= sat_io(ACC_W'(bias));
        out_sat   <= clip | ovf_io(ACC_W'(ang)) | ovf_io(ACC_W'(bias));
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    status.mul_done = mul_done;
    status.div_done = div_done;
    status.s_pos    = !s[ACC_W-1] && (|s);
    status.out_full = out_valid;
  end

endmodule

`default_nettype wire

/* hdl/akf_ctrl.sv */
// Sequencer that steps the datapath through one filter update.
`timescale 1ns / 1ps
`default_nettype none

module akf_ctrl import akf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  localparam int STEPS = 17;
  localparam int SW    = $clog2(STEPS);
  localparam logic [SW-1:0] LAST_STEP = SW'(STEPS - 1);

  typedef enum logic [1:0] {U_NONE, U_MUL, U_DIV} unit_t;

  typedef struct packed {
    unit_t unit;
    msel_t msel;
    dsel_t dsel;
    op_t   op;
  } step_t;

  typedef enum logic [1:0] {ST_IDLE, ST_ISSUE, ST_WAIT, ST_FINISH} state_t;

  function automatic step_t decode(input logic [SW-1:0] idx);
    step_t r;
    r = '{unit: U_NONE, msel: M_DT_RATE, dsel: D_P00, op: OP_NONE};
    case (idx)
      5'd0:    r = '{unit: U_NONE, msel: M_DT_RATE, dsel: D_P00, op: OP_RATE};
      5'd1:    r = '{unit: U_MUL,  msel: M_DT_RATE, dsel: D_P00, op: OP_ANG_PRED};
      5'd2:    r = '{unit: U_MUL,  msel: M_DT_P11,  dsel: D_P00, op: OP_SAVE_DP};
      5'd3:    r = '{unit: U_NONE, msel: M_DT_RATE, dsel: D_P00, op: OP_T};
      5'd4:    r = '{unit: U_MUL,  msel: M_DT_T,    dsel: D_P00, op: OP_P00_PRED};
      5'd5:    r = '{unit: U_NONE, msel: M_DT_RATE, dsel: D_P00, op: OP_P01_PRED};
      5'd6:    r = '{unit: U_MUL,  msel: M_QB_DT,   dsel: D_P00, op: OP_P11_PRED};
      5'd7:    r = '{unit: U_NONE, msel: M_DT_RATE, dsel: D_P00, op: OP_S};
      5'd8:    r = '{unit: U_DIV,  msel: M_DT_RATE, dsel: D_P00, op: OP_K0};
      5'd9:    r = '{unit: U_DIV,  msel: M_DT_RATE, dsel: D_P10, op: OP_K1};
      5'd10:   r = '{unit: U_NONE, msel: M_DT_RATE, dsel: D_P00, op: OP_Y};
      5'd11:   r = '{unit: U_MUL,  msel: M_K0_Y,    dsel: D_P00, op: OP_ANG_UPD};
      5'd12:   r = '{unit: U_MUL,  msel: M_K1_Y,    dsel: D_P00, op: OP_BIAS_UPD};
      5'd13:   r = '{unit: U_MUL,  msel: M_K0_P01,  dsel: D_P00, op: OP_SAVE_DP};
      5'd14:   r = '{unit: U_MUL,  msel: M_K1_P01,  dsel: D_P00, op: OP_P11_UPD};
      5'd15:   r = '{unit: U_MUL,  msel: M_K1_P00,  dsel: D_P00, op: OP_P10_UPD};
      5'd16:   r = '{unit: U_MUL,  msel: M_K0_P00,  dsel: D_P00, op: OP_P00_UPD};
      default: r = '{unit: U_NONE, msel: M_DT_RATE, dsel: D_P00, op: OP_NONE};
    endcase
    return r;
  endfunction

  state_t        state;
  logic [SW-1:0] step;
  step_t         cur;
  logic          unit_done;

  always_comb begin
    cur       = decode(step);
    unit_done = status.mul_done | status.div_done;
    in_ready  = (state == ST_IDLE);

    cmd           = '0;
    cmd.op        = OP_NONE;
    cmd.msel      = cur.msel;
    cmd.dsel      = cur.dsel;
    case (state)
      ST_IDLE:   cmd.load = in_valid;
      ST_ISSUE: begin
        case (cur.unit)
          U_NONE:  cmd.op        = cur.op;
          U_MUL:   cmd.mul_start = 1'b1;
          U_DIV:   cmd.div_start = status.s_pos;
          default: cmd.op        = OP_NONE;
        endcase
      end
      ST_WAIT:   cmd.op       = unit_done ? cur.op : OP_NONE;
      ST_FINISH: cmd.out_load = !status.out_full;
      default:   cmd.op       = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_ISSUE;
            step  <= '0;
          end
        end
        ST_ISSUE: begin
          case (cur.unit)
            U_NONE: begin
              if (step == LAST_STEP) begin
                state <= ST_FINISH;
              end else begin
                step <= step + 1'b1;
              end
            end
            U_MUL:   state <= ST_WAIT;
            // non-positive divisor: gains stay zero, corrections change nothing
            U_DIV:   state <= status.s_pos ? ST_WAIT : ST_FINISH;
            default: state <= ST_IDLE;
          endcase
        end
        ST_WAIT: begin
          if (unit_done) begin
            if (step == LAST_STEP) begin
              state <= ST_FINISH;
            end else begin
              step  <= step + 1'b1;
              state <= ST_ISSUE;
            end
          end
        end
        ST_FINISH: begin
          if (!status.out_full) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

/* hdl/angle_kalman_filter_core.sv */
// Top level of the two-state angle and rate-bias Kalman filter core.
//
// The core keeps an angle estimate, a rate-bias estimate and a 2x2 error
// covariance. For each accepted request (measured angle and rate, Q4.28) it
// predicts the angle with the bias-corrected rate times step_time, grows the
// covariance by the process noises, forms both gains by dividing by
// (P00 + measurement_noise), corrects angle and bias and shrinks the
// covariance. It returns one result request per input: the filtered angle,
// the bias (both Q4.28, saturated) and a flag that is set when any value was
// clipped during that update. Noises and step time are unsigned Q3.28;
// covariance and gains are Q4.28. One update runs at a time: a single
// shift-add multiplier (one bit per cycle, ten products) and a restoring
// divider (two gains) are shared by all steps. When the divisor is not
// positive, the gains stay zero and the correction is skipped. The input is
// ready again once the result sits in the output register; a held result
// stalls only the hand-off of the next one. Configuration registers may be
// written at any time the core is idle and take effect on the next update.
`timescale 1ns / 1ps
`default_nettype none

module angle_kalman_filter_core import akf_pkg::*; #(
  parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  akf_in_if.sink               in_ch,
  akf_out_if.source            out_ch,
  input  logic                 write_enable,
  input  logic [CFG_IDX_W-1:0] reg_index,
  input  logic [CFG_W-1:0]     write_data
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // Sequencer: accept a request, walk the update steps, hand off the result.
  akf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // State, configuration, arithmetic units and the output register.
  akf_datapath #(.W(WORD_WIDTH)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .in_angle     (in_ch.measured_angle),
    .in_rate      (in_ch.measured_rate),
    .write_enable (write_enable),
    .reg_index    (reg_index),
    .write_data   (write_data),
    .out_ready    (out_ch.ready),
    .out_valid    (out_ch.valid),
    .out_angle    (out_ch.filtered_angle),
    .out_bias     (out_ch.bias_estimate),
    .out_sat      (out_ch.saturated)
  );

endmodule

`default_nettype wire

/* hdl/akf_checker.sv */
// Port-level checks on the filter core, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module akf_checker import akf_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic signed [IO_W-1:0] out_angle,
  input logic signed [IO_W-1:0] out_bias
);

  // one update at a time: input closes right after a request is taken
  a_in_single: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input stayed ready after accepting a request");

  // single output register: no back-to-back results
  a_out_single: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready) |=> !out_valid)
    else $error("result shown again right after hand-off");

  // a new result appears exactly as the core returns to idle
  a_out_idle: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> in_ready)
    else $error("result appeared while an update was still running");

  // held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_angle) && $stable(out_bias)))
    else $error("stalled result changed");

endmodule

bind angle_kalman_filter_core akf_checker u_akf_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_angle (out_ch.filtered_angle),
  .out_bias  (out_ch.bias_estimate)
);

`default_nettype wire
